### src/sfa_pkg.sv
// ----------------------------------------------------------------------------
// Segment fit allocator package
// Shared function codes, status codes, controller state type and cell control types.
// ----------------------------------------------------------------------------
package sfa_pkg;

    typedef enum logic [2:0] {
        FN_LOAD    = 3'd0,
        FN_FIRST   = 3'd1,
        FN_BEST    = 3'd2,
        FN_WORST   = 3'd3,
        FN_FREE    = 3'd4,
        FN_COMPACT = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_COMPACT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_SHIFT_UP,
        OP_ROTATE,
        OP_MERGE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     busy_val;
    } t_cell_ctl;

endpackage

### src/sfa_cell.sv
// ----------------------------------------------------------------------------
// Segment fit allocator cell
// Holds one table entry; is written, or shifts, rotates or merges with its neighbors.
// ----------------------------------------------------------------------------
module sfa_cell #(
    parameter int SIZE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfa_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_sel,
    input  logic [SIZE_BITS-1:0]  i_wr_size,
    input  logic [SIZE_BITS-1:0]  i_prev_size,
    input  logic                  i_prev_busy,
    input  logic [SIZE_BITS-1:0]  i_next_size,
    input  logic                  i_next_busy,
    input  logic                  i_merge,
    output logic [SIZE_BITS-1:0]  o_size,
    output logic                  o_busy
);
    import sfa_pkg::*;

    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_busy, n_busy;

    always_comb begin
        n_size = r_size;
        n_busy = r_busy;
        case (i_ctl.op)
            OP_WRITE: begin
                if (i_sel) begin
                    n_size = i_wr_size;
                    n_busy = i_ctl.busy_val;
                end
            end
            OP_SHIFT_UP: begin
                if (i_sel) begin
                    n_size = i_prev_size;
                    n_busy = i_prev_busy;
                end
            end
            OP_ROTATE: begin
                n_size = i_next_size;
                n_busy = i_next_busy;
            end
            OP_MERGE: begin
                if (i_sel) begin
                    n_size = r_size + i_next_size;
                end else if (i_merge) begin
                    n_size = i_next_size;
                    n_busy = i_next_busy;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign o_size = r_size;
    assign o_busy = r_busy;

endmodule

### src/segment_fit_allocator.sv
// ----------------------------------------------------------------------------
// Segment fit allocator
// Ordered segment table held in a rotating row of cells, with a scan
// controller for load, first/best/worst fit, free and compact.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// command   in         start and not busy: func, amount, ordinal
// result    out        o_done for one cycle: status, index, sums, count
//
// The table rotates one entry per cycle through the cells. A fit or free scans
// the whole row and then decides; a split then shifts the entries above the
// pick up by one place. A compact walks the entries, merging free neighbours.
// Reset clears the busy marks, the count and the sums; sizes need no reset.
// The receiver cannot stall; busy holds off new commands.
// ----------------------------------------------------------------------------
module segment_fit_allocator #(
    parameter int MAX_SEGMENTS = 32,
    parameter int SIZE_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_func,
    input  logic [SIZE_BITS-1:0]             i_amount,
    input  logic [4:0]                       i_ordinal,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [4:0]                       o_segment_index,
    output logic [20:0]                      o_free_total,
    output logic [20:0]                      o_total_size,
    output logic [5:0]                       o_segment_count
);
    import sfa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SUMW = SIZE_BITS + CW;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    t_state r_state, n_state;
    t_cell_ctl ctl;
    logic [SIZE_BITS-1:0] c_size [MAX_SEGMENTS];
    logic                 c_busy [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] sel;
    logic [SIZE_BITS-1:0] wr_size;
    logic [MAX_SEGMENTS-1:0] shift_dn;

    logic [2:0]            r_func;
    logic [SIZE_BITS-1:0]  r_amt;
    logic [4:0]            r_ord;
    logic [CW-1:0]         r_count, n_count;
    logic [SUMW-1:0]       r_free, n_free, r_whole, n_whole;
    logic [CW-1:0]         r_step, n_step;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_pick, n_pick;
    logic [SIZE_BITS-1:0]  r_psize, n_psize;
    logic [4:0]            r_seen, n_seen;
    logic [CW-1:0]         r_wr, n_wr;
    logic [1:0]            r_st, n_st;
    logic [4:0]            r_where, n_where;

    // Cell 0 always presents the entry at table position r_step during a
    // rotation sweep; the whole row rotates back to its origin at the end.
    logic [SIZE_BITS-1:0] h_size;
    logic                 h_busy, h_valid, h_fit, h_take;
    logic [CW-1:0]        tgt;

    assign h_size  = c_size[0];
    assign h_busy  = c_busy[0];
    assign h_valid = r_step < r_count;
    assign h_fit   = h_valid && !h_busy && h_size >= r_amt;

    always_comb begin
        h_take = 1'b0;
        if (h_fit) begin
            if (!r_found) begin
                h_take = 1'b1;
            end else begin
                case (r_func)
                    FN_BEST:  h_take = h_size < r_psize;
                    FN_WORST: h_take = h_size > r_psize;
                    default:  h_take = 1'b0;
                endcase
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            localparam int PV = (g == 0) ? 0 : g - 1;
            localparam int NX = (g == MAX_SEGMENTS - 1) ? 0 : g + 1;
            sfa_cell #(.SIZE_BITS(SIZE_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_sel       (sel[g]),
                .i_wr_size   (wr_size),
                .i_prev_size (c_size[PV]),
                .i_prev_busy (c_busy[PV]),
                .i_next_size (c_size[NX]),
                .i_next_busy (c_busy[NX]),
                .i_merge     (shift_dn[g]),
                .o_size      (c_size[g]),
                .o_busy      (c_busy[g])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_func)
                        FN_FIRST, FN_BEST, FN_WORST, FN_FREE: n_state = S_SCAN;
                        FN_COMPACT: n_state = S_COMPACT;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_step == CW'(MAX_SEGMENTS - 1)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_found && r_psize > r_amt && r_count < CW'(MAX_SEGMENTS)
                    && r_func != FN_FREE) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_step == CW'(r_pick) + 1'b1) n_state = S_DONE;
            end
            S_COMPACT: begin
                if (r_wr == r_count) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and cell control.
    always_comb begin
        n_count = r_count;  n_free = r_free;  n_whole = r_whole;
        n_step = r_step;    n_found = r_found; n_pick = r_pick;
        n_psize = r_psize;  n_seen = r_seen;  n_wr = r_wr;
        n_st = r_st;        n_where = r_where;
        ctl.op = OP_HOLD;   ctl.busy_val = 1'b0;
        sel = '0;           wr_size = r_amt;
        tgt = '0;
        case (r_state)
            S_IDLE: begin
                n_step = '0; n_found = 1'b0; n_pick = '0; n_seen = '0;
                n_wr = '0; n_st = ST_OK; n_where = '0;
                if (start && i_func == FN_LOAD) begin
                    if (i_amount == '0 || r_count >= CW'(MAX_SEGMENTS)) begin
                        n_st = ST_FULL;
                    end else begin
                        ctl.op = OP_WRITE;
                        wr_size = i_amount;
                        sel[r_count[IW-1:0]] = 1'b1;
                        n_where = 5'(r_count);
                        n_count = r_count + 1'b1;
                        n_free = r_free + SUMW'(i_amount);
                        n_whole = r_whole + SUMW'(i_amount);
                    end
                end else if (start && (i_func == FN_FIRST || i_func == FN_BEST
                             || i_func == FN_WORST) && i_amount == '0) begin
                    n_st = ST_FULL;
                end
            end
            S_SCAN: begin
                ctl.op = OP_ROTATE;
                n_step = r_step + 1'b1;
                if (r_func == FN_FREE) begin
                    if (h_valid && h_busy && !r_found) begin
                        if (r_seen == r_ord) begin
                            n_found = 1'b1;
                            n_pick = r_step[IW-1:0];
                            n_psize = h_size;
                        end
                        n_seen = r_seen + 1'b1;
                    end
                end else if (r_st == ST_OK && h_take) begin
                    n_found = 1'b1;
                    n_pick = r_step[IW-1:0];
                    n_psize = h_size;
                end
            end
            S_DECIDE: begin
                n_step = r_count;
                if (r_st != ST_OK) begin
                    n_st = r_st;
                end else if (r_func == FN_FREE) begin
                    if (r_found) begin
                        ctl.op = OP_WRITE;
                        wr_size = r_psize;
                        sel[r_pick] = 1'b1;
                        n_free = r_free + SUMW'(r_psize);
                        n_where = 5'(r_pick);
                    end else begin
                        n_st = ST_NOTFOUND;
                    end
                end else if (!r_found) begin
                    n_st = ST_NOFIT;
                end else if (r_psize > r_amt && r_count >= CW'(MAX_SEGMENTS)) begin
                    n_st = ST_FULL;
                end else begin
                    n_free = r_free - SUMW'(r_amt);
                    n_where = 5'(r_pick);
                    ctl.op = OP_WRITE;
                    ctl.busy_val = 1'b1;
                    sel[r_pick] = 1'b1;
                end
            end
            S_SHIFT: begin
                // Walk downward from the old end, moving one entry up per
                // cycle, then write the remainder after the busy head.
                tgt = r_step;
                n_step = r_step - 1'b1;
                if (r_step == CW'(r_pick) + 1'b1) begin
                    ctl.op = OP_WRITE;
                    wr_size = r_psize - r_amt;
                    sel[tgt[IW-1:0]] = 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    ctl.op = OP_SHIFT_UP;
                    sel[tgt[IW-1:0]] = 1'b1;
                end
            end
            S_COMPACT: begin
                // Cell r_wr-1 absorbs cell r_wr when both are free and their sum fits; the row
                // above r_wr then slides down by one.
                n_step = r_step + 1'b1;
                if (r_wr != '0 && r_wr < r_count && !c_busy[r_wr[IW-1:0] - 1'b1]
                    && !c_busy[r_wr[IW-1:0]]
                    && ({1'b0, c_size[r_wr[IW-1:0] - 1'b1]}
                        + {1'b0, c_size[r_wr[IW-1:0]]}) <= {1'b0, SIZE_MAX}) begin
                    ctl.op = OP_MERGE;
                    for (int k = 0; k < MAX_SEGMENTS; k++) begin
                        sel[k] = (CW'(k) == r_wr - 1'b1);
                    end
                    n_count = r_count - 1'b1;
                end else if (r_wr < r_count) begin
                    n_wr = r_wr + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_DONE && r_func == FN_FIRST) begin
            n_st = r_st;
        end
    end

    // Merge moves cells above the absorbing one down by one place.
    always_comb begin
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            shift_dn[k] = (ctl.op == OP_MERGE) && (CW'(k) >= r_wr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_func <= i_func;
            r_amt  <= i_amount;
            r_ord  <= i_ordinal;
        end
        r_step  <= n_step;
        r_pick  <= n_pick;
        r_psize <= n_psize;
        r_seen  <= n_seen;
        r_wr    <= n_wr;
        r_where <= n_where;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_free  <= '0;
            r_whole <= '0;
            r_found <= 1'b0;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_free  <= n_free;
            r_whole <= n_whole;
            r_found <= n_found;
            r_st    <= n_st;
        end
    end

    // Outputs.
    always_comb begin
        busy            = r_state != S_IDLE;
        o_done          = r_state == S_DONE;
        o_status        = r_st;
        o_segment_index = (r_st == ST_OK) ? r_where : 5'd0;
        o_free_total    = 21'(r_free);
        o_total_size    = 21'(r_whole);
        o_segment_count = 6'(r_count);
    end

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS)) else $error("count overflow");
    a_free_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_whole) else $error("free exceeds total");

endmodule
